// ----- rtl/core/tscu_pkg.sv -----
// Shared types, constants and the slot classification function of the TDD slot classifier.
package tscu_pkg;

  localparam int unsigned SlotW          = 10;
  localparam int unsigned IdxW           = 8;
  localparam int unsigned SymW           = 2;
  localparam int unsigned SymbolsPerSlot = 14;
  localparam int unsigned PatW           = SymW * SymbolsPerSlot;
  localparam int unsigned ClassW         = 2;

  localparam int unsigned MaxPeriodSlots = 256;
  localparam int unsigned AddrW          = $clog2(MaxPeriodSlots);

  localparam int unsigned PeriodCfgW     = 9;
  localparam int unsigned PeriodW        = PeriodCfgW + 1;
  localparam int unsigned RemW           = PeriodW;

  localparam int unsigned DivBitsPerStep = 4;
  localparam int unsigned DivSteps       = 3;
  localparam int unsigned DivW           = DivBitsPerStep * DivSteps;
  localparam int unsigned StepCntW       = $clog2(DivSteps + 1);

  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = PeriodCfgW;

  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned QPtrW          = $clog2(QueueDepth);
  localparam int unsigned QCntW          = $clog2(QueueDepth + 1);

  localparam logic [SymW-1:0] SYM_DL   = 2'd0;
  localparam logic [SymW-1:0] SYM_UL   = 2'd1;
  localparam logic [SymW-1:0] SYM_FLEX = 2'd2;

  typedef enum logic [ClassW-1:0] {
    CLASS_DL    = 2'd0,
    CLASS_UL    = 2'd1,
    CLASS_MIXED = 2'd2,
    CLASS_BOTH  = 2'd3
  } slot_class_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DUPLEX_IS_FDD         = 3'd0,
    CFG_FIRST_PERIOD_SLOTS    = 3'd1,
    CFG_SECOND_PERIOD_SLOTS   = 3'd2,
    CFG_FIRST_PATTERN_LOADED  = 3'd3,
    CFG_SECOND_PATTERN_LOADED = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                  duplex_is_fdd;
    logic [PeriodCfgW-1:0] first_period_slots;
    logic [PeriodCfgW-1:0] second_period_slots;
    logic                  first_pattern_loaded;
    logic                  second_pattern_loaded;
  } cfg_t;

  typedef struct packed {
    logic              is_write;
    logic              use_store;
    slot_class_e       fixed_class;
    logic [AddrW-1:0]  addr;
    logic [PatW-1:0]   pattern;
  } cmd_t;

  function automatic slot_class_e classify(input logic [PatW-1:0] pattern);
    logic [SymW-1:0] s0;
    logic            later_nz;
    slot_class_e     cls;
    s0       = pattern[SymW-1:0];
    later_nz = |pattern[PatW-1:SymW];
    if (s0 == SYM_UL) begin
      cls = CLASS_UL;
    end else if (s0 == SYM_FLEX) begin
      cls = CLASS_MIXED;
    end else if (later_nz) begin
      cls = CLASS_MIXED;
    end else begin
      cls = CLASS_DL;
    end
    return cls;
  endfunction

endpackage

// ----- rtl/core/tscu_intf.sv -----
// Channel interfaces of the TDD slot classifier: item input, result output, register writes.
interface tscu_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [tscu_pkg::SlotW-1:0]   slot_number;
  logic [tscu_pkg::IdxW-1:0]    entry_index;
  logic [tscu_pkg::PatW-1:0]    symbol_pattern;

  modport source(output valid, action, slot_number, entry_index, symbol_pattern,
                 input ready);
  modport sink(input valid, action, slot_number, entry_index, symbol_pattern,
               output ready);
endinterface

interface tscu_out_if;
  logic                         valid;
  logic                         ready;
  logic [tscu_pkg::ClassW-1:0]  slot_class;

  modport source(output valid, slot_class, input ready);
  modport sink(input valid, slot_class, output ready);
endinterface

interface tscu_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tscu_pkg::CfgIdxW-1:0] index;
  logic [tscu_pkg::CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/tscu_ram.sv -----
// Generic single-port RAM with registered read data.
module tscu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tscu_front.sv -----
// Front end: accepts items, reduces query slots modulo the combined period, builds commands.
module tscu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  tscu_in_if.sink         in_i,
  input  tscu_pkg::cfg_t  cfg_i,
  output tscu_pkg::cmd_t  cmd_o,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i
);

  logic                               busy_q, busy_d;
  logic [tscu_pkg::StepCntW-1:0]      steps_q, steps_d;
  logic                               is_write_q;
  logic [tscu_pkg::IdxW-1:0]          idx_q;
  logic [tscu_pkg::PatW-1:0]          pat_q;
  logic [tscu_pkg::DivW-1:0]          dividend_q;
  logic [tscu_pkg::RemW-1:0]          rem_q;

  logic [tscu_pkg::PeriodW-1:0]       period;
  logic [tscu_pkg::RemW:0]            rem_w;
  logic [tscu_pkg::DivW-1:0]          div_w;
  logic [tscu_pkg::RemW-1:0]          rem_step;
  logic [tscu_pkg::DivW-1:0]          div_step;
  logic                               accept;
  logic                               done;
  logic                               is_write_in;
  logic                               skip_div;
  logic                               sel_second;
  logic                               loaded;

  assign period = {1'b0, cfg_i.first_period_slots} + {1'b0, cfg_i.second_period_slots};

  assign done        = busy_q && (steps_q == '0);
  assign in_i.ready  = !busy_q || (done && cmd_ready_i);
  assign accept      = in_i.valid && in_i.ready;
  assign is_write_in = (tscu_pkg::action_e'(in_i.action) == tscu_pkg::ACT_WRITE);
  assign skip_div    = is_write_in || cfg_i.duplex_is_fdd || (period == '0);

  // Restoring remainder, several dividend bits per cycle
  always_comb begin
    rem_w = {1'b0, rem_q};
    div_w = dividend_q;
    for (int k = 0; k < tscu_pkg::DivBitsPerStep; k++) begin
      rem_w = {rem_w[tscu_pkg::RemW-1:0], div_w[tscu_pkg::DivW-1]};
      div_w = {div_w[tscu_pkg::DivW-2:0], 1'b0};
      if (rem_w >= {1'b0, period}) begin
        rem_w = rem_w - {1'b0, period};
      end
    end
    rem_step = rem_w[tscu_pkg::RemW-1:0];
    div_step = div_w;
  end

  always_comb begin
    busy_d  = busy_q;
    steps_d = steps_q;
    if (accept) begin
      busy_d  = 1'b1;
      steps_d = skip_div ? '0 : tscu_pkg::StepCntW'(tscu_pkg::DivSteps);
    end else if (done && cmd_ready_i) begin
      busy_d = 1'b0;
    end else if (busy_q && (steps_q != '0)) begin
      steps_d = steps_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      busy_q  <= busy_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_write_q <= is_write_in;
      idx_q      <= in_i.entry_index;
      pat_q      <= in_i.symbol_pattern;
      dividend_q <= tscu_pkg::DivW'(in_i.slot_number);
      rem_q      <= '0;
    end else if (busy_q && (steps_q != '0)) begin
      dividend_q <= div_step;
      rem_q      <= rem_step;
    end
  end

  assign sel_second = (cfg_i.second_period_slots != '0) &&
                      (rem_q >= {1'b0, cfg_i.first_period_slots});
  assign loaded     = sel_second ? cfg_i.second_pattern_loaded : cfg_i.first_pattern_loaded;

  always_comb begin
    cmd_o.is_write    = is_write_q;
    cmd_o.use_store   = !is_write_q && !cfg_i.duplex_is_fdd && (period != '0) && loaded;
    cmd_o.fixed_class = cfg_i.duplex_is_fdd ? tscu_pkg::CLASS_BOTH : tscu_pkg::CLASS_DL;
    cmd_o.addr        = is_write_q ? tscu_pkg::AddrW'(idx_q) : rem_q[tscu_pkg::AddrW-1:0];
    cmd_o.pattern     = pat_q;
  end

  assign cmd_valid_o = done;

  a_rem_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !is_write_q && (period != '0) |-> rem_q < period)
    else $error("remainder not below combined period");

  a_div_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (steps_q != '0) |=> busy_q && (steps_q == $past(steps_q) - 1'b1))
    else $error("division step skipped or aborted");

endmodule

// ----- rtl/core/tscu_queue.sv -----
// Two-entry command queue between front end and back end.
module tscu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tscu_pkg::cmd_t  push_cmd_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output tscu_pkg::cmd_t  pop_cmd_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);

  tscu_pkg::cmd_t                entry_q [tscu_pkg::QueueDepth];
  logic [tscu_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [tscu_pkg::QCntW-1:0]    count_q;
  logic                          push, pop;

  assign push_ready_o = (count_q != tscu_pkg::QCntW'(tscu_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == tscu_pkg::QPtrW'(tscu_pkg::QueueDepth - 1)) ? '0
                                                                              : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == tscu_pkg::QPtrW'(tscu_pkg::QueueDepth - 1)) ? '0
                                                                              : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tscu_pkg::QCntW'(tscu_pkg::QueueDepth))
    else $error("queue count out of range");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with empty count");

endmodule

// ----- rtl/core/tscu_back.sv -----
// Back end: pattern store access, slot classification and output register.
module tscu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tscu_pkg::cmd_t  cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  tscu_out_if.source      out_o
);

  logic                         s1_valid_q;
  logic                         s1_use_store_q;
  tscu_pkg::slot_class_e        s1_fixed_q;
  logic                         out_valid_q;
  tscu_pkg::slot_class_e        out_class_q;

  logic                         out_free;
  logic                         s1_adv;
  logic                         s1_free;
  logic                         pop;
  logic                         ram_we, ram_re;
  logic [tscu_pkg::PatW-1:0]    ram_rdata;

  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign s1_free     = !s1_valid_q || s1_adv;
  assign cmd_ready_o = cmd_i.is_write || s1_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign ram_we      = pop && cmd_i.is_write;
  assign ram_re      = pop && !cmd_i.is_write && cmd_i.use_store;

  tscu_ram #(
    .Width(tscu_pkg::PatW),
    .Depth(tscu_pkg::MaxPeriodSlots)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (cmd_i.addr),
    .wdata_i(cmd_i.pattern),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && !cmd_i.is_write) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !cmd_i.is_write) begin
      s1_use_store_q <= cmd_i.use_store;
      s1_fixed_q     <= cmd_i.fixed_class;
    end
    if (s1_adv) begin
      out_class_q <= s1_use_store_q ? tscu_pkg::classify(ram_rdata) : s1_fixed_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.slot_class = out_class_q;

endmodule

// ----- rtl/core/tdd_slot_type_classifier_unit.sv -----
// Top level of the TDD slot classifier: register file, front end, queue and back end.
//
// Channels: in_i carries items (action 0 writes one 14-symbol pattern into the store
// at entry_index, action 1 queries slot_number); out_o returns one slot_class per
// query and nothing for a write; cfg_i, always ready, writes the five mode and period
// registers; it must be used only while no transaction is in flight (not enforced).
// Path: a query passes the front-end registers, the remainder unit, the queue, the
// store read stage and the output register; FDD and zero-period queries skip division.
// Issue: the front end takes a new item only once its last command enters the queue;
// a TDD query first runs through the remainder unit in the front end, which retires 4
// dividend bits per cycle.
// The back end (store read, classification, output register) runs one command per
// cycle while out_o is ready, behind a two-entry queue, so the front end keeps
// accepting while a result waits. When out_o stalls, results hold in the output
// register, then the queue fills and in_i.ready drops.
// Reset clears control and config registers, not data ones, and empties the pipeline;
// the pattern store is not cleared and must be written before its entries are queried.
module tdd_slot_type_classifier_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  tscu_cfg_if.sink  cfg_i,
  tscu_in_if.sink   in_i,
  tscu_out_if.source out_o
);

  tscu_pkg::cfg_t  cfg_q;
  tscu_pkg::cmd_t  front_cmd;
  logic            front_valid;
  logic            front_ready;
  tscu_pkg::cmd_t  back_cmd;
  logic            back_valid;
  logic            back_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (tscu_pkg::cfg_idx_e'(cfg_i.index))
        tscu_pkg::CFG_DUPLEX_IS_FDD: begin
          cfg_q.duplex_is_fdd <= cfg_i.data[0];
        end
        tscu_pkg::CFG_FIRST_PERIOD_SLOTS: begin
          cfg_q.first_period_slots <= cfg_i.data[tscu_pkg::PeriodCfgW-1:0];
        end
        tscu_pkg::CFG_SECOND_PERIOD_SLOTS: begin
          cfg_q.second_period_slots <= cfg_i.data[tscu_pkg::PeriodCfgW-1:0];
        end
        tscu_pkg::CFG_FIRST_PATTERN_LOADED: begin
          cfg_q.first_pattern_loaded <= cfg_i.data[0];
        end
        tscu_pkg::CFG_SECOND_PATTERN_LOADED: begin
          cfg_q.second_pattern_loaded <= cfg_i.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  tscu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_q),
    .cmd_o      (front_cmd),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(front_ready)
  );

  tscu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cmd_i  (front_cmd),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .pop_cmd_o   (back_cmd),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready)
  );

  tscu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (back_cmd),
    .cmd_valid_i(back_valid),
    .cmd_ready_o(back_ready),
    .out_o      (out_o)
  );

endmodule
